FILE: sv/argb_blend_pkg.sv
package argb_blend_pkg;

    // Widths of the RGB565 channels and the destination alpha nibble.
    localparam int unsigned RW = 5;
    localparam int unsigned GW = 6;
    localparam int unsigned BW = 5;
    localparam int unsigned NW = 4;

    // Source alpha codes that bypass the arithmetic.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // Saturation limits.
    localparam logic [RW-1:0] R_MAX   = 5'h1f;
    localparam logic [GW-1:0] G_MAX   = 6'h3f;
    localparam logic [BW-1:0] B_MAX   = 5'h1f;
    localparam logic [NW-1:0] NIB_MAX = 4'h7;

    // What the final stage does with a pixel.
    typedef enum logic [1:0] {
        MODE_BLEND,
        MODE_OPAQUE,
        MODE_PASS
    } t_mode;

    // One pixel after decode.
    typedef struct packed {
        t_mode          mode;
        logic [8:0]     s;
        logic [RW-1:0]  src_r;
        logic [GW-1:0]  src_g;
        logic [BW-1:0]  src_b;
        logic [15:0]    dst;
        logic [NW-1:0]  nib;
        logic [2:0]     a_hi;
    } t_lane_dec;

    // One pixel after the multipliers.
    typedef struct packed {
        t_mode          mode;
        logic [13:0]    prod_r;
        logic [14:0]    prod_g;
        logic [13:0]    prod_b;
        logic [12:0]    prod_n;
        logic [RW-1:0]  src_r;
        logic [GW-1:0]  src_g;
        logic [BW-1:0]  src_b;
        logic [15:0]    dst;
        logic [NW-1:0]  nib;
        logic [2:0]     a_hi;
    } t_lane_mul;

endpackage

FILE: sv/argb8888_over_rgb565_a3_blend_core.sv
// Blends a pair of ARGB8888 source pixels onto a pair of RGB565 destination
// pixels that share one alpha byte (high nibble for the even pixel, low nibble
// for the odd one). Each request passes through three register stages: decode
// of the source alpha, the per-channel multiplies by (256 - A), and the shift,
// add and saturation that also forms the output register. A new pixel pair is
// taken in every cycle unless back-pressure stalls it; a result is valid once
// it has passed all three registers. Each stage holds its request while the
// stage after it is full and stalled, so back-pressure on the output only stops
// the input once all three stages are occupied.
module argb8888_over_rgb565_a3_blend_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_src_even,
    input  logic [31:0] i_src_odd,
    input  logic [15:0] i_dst_even,
    input  logic [15:0] i_dst_odd,
    input  logic [7:0]  i_dst_alpha_pair,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_even,
    output logic [15:0] o_out_odd,
    output logic [7:0]  o_out_alpha_pair
);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    argb_blend_pkg::t_lane_dec r_dec [2];
    argb_blend_pkg::t_lane_dec n_dec [2];
    argb_blend_pkg::t_lane_mul r_mul [2];
    argb_blend_pkg::t_lane_mul n_mul [2];
    logic [15:0]                    r_pix [2];
    logic [15:0]                    n_pix [2];
    logic [argb_blend_pkg::NW-1:0]  r_nib [2];
    logic [argb_blend_pkg::NW-1:0]  n_nib [2];

    logic [31:0]                    w_src [2];
    logic [15:0]                    w_dst [2];
    logic [argb_blend_pkg::NW-1:0]  w_dnib [2];

    // A stage may load when it is empty or its contents move on.
    assign w_rdy3     = !r_v3 || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;

    assign w_src[0]  = i_src_even;
    assign w_src[1]  = i_src_odd;
    assign w_dst[0]  = i_dst_even;
    assign w_dst[1]  = i_dst_odd;
    assign w_dnib[0] = i_dst_alpha_pair[7:4];
    assign w_dnib[1] = i_dst_alpha_pair[3:0];

    // Stage one: classify the source alpha and split the channels.
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (w_src[i][31:24] == argb_blend_pkg::ALPHA_OPAQUE) begin
                n_dec[i].mode = argb_blend_pkg::MODE_OPAQUE;
            end else if (w_src[i][31:24] == argb_blend_pkg::ALPHA_CLEAR) begin
                n_dec[i].mode = argb_blend_pkg::MODE_PASS;
            end else begin
                n_dec[i].mode = argb_blend_pkg::MODE_BLEND;
            end
            n_dec[i].s     = 9'h100 - {1'b0, w_src[i][31:24]};
            n_dec[i].src_r = w_src[i][23:19];
            n_dec[i].src_g = w_src[i][15:10];
            n_dec[i].src_b = w_src[i][7:3];
            n_dec[i].dst   = w_dst[i];
            n_dec[i].nib   = w_dnib[i];
            n_dec[i].a_hi  = w_src[i][31:29];
        end
    end

    // Stage two: weight each destination channel and the nibble by (256 - A).
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_mul[i].mode   = r_dec[i].mode;
            n_mul[i].prod_r = 14'(r_dec[i].s) * 14'(r_dec[i].dst[15:11]);
            n_mul[i].prod_g = 15'(r_dec[i].s) * 15'(r_dec[i].dst[10:5]);
            n_mul[i].prod_b = 14'(r_dec[i].s) * 14'(r_dec[i].dst[4:0]);
            n_mul[i].prod_n = 13'(r_dec[i].s) * 13'(r_dec[i].nib);
            n_mul[i].src_r  = r_dec[i].src_r;
            n_mul[i].src_g  = r_dec[i].src_g;
            n_mul[i].src_b  = r_dec[i].src_b;
            n_mul[i].dst    = r_dec[i].dst;
            n_mul[i].nib    = r_dec[i].nib;
            n_mul[i].a_hi   = r_dec[i].a_hi;
        end
    end

    // Stage three: drop the fraction, add the source, saturate and pick the case.
    always_comb begin
        logic [6:0] sum_r;
        logic [7:0] sum_g;
        logic [6:0] sum_b;
        logic [5:0] sum_n;
        logic [argb_blend_pkg::RW-1:0] res_r;
        logic [argb_blend_pkg::GW-1:0] res_g;
        logic [argb_blend_pkg::BW-1:0] res_b;
        logic [argb_blend_pkg::NW-1:0] res_n;
        for (int i = 0; i < 2; i++) begin
            sum_r = 7'(r_mul[i].prod_r[13:8]) + 7'(r_mul[i].src_r);
            sum_g = 8'(r_mul[i].prod_g[14:8]) + 8'(r_mul[i].src_g);
            sum_b = 7'(r_mul[i].prod_b[13:8]) + 7'(r_mul[i].src_b);
            sum_n = 6'(r_mul[i].prod_n[12:8]) + 6'(r_mul[i].a_hi);
            res_r = (sum_r > 7'(argb_blend_pkg::R_MAX)) ? argb_blend_pkg::R_MAX
                                                        : sum_r[4:0];
            res_g = (sum_g > 8'(argb_blend_pkg::G_MAX)) ? argb_blend_pkg::G_MAX
                                                        : sum_g[5:0];
            res_b = (sum_b > 7'(argb_blend_pkg::B_MAX)) ? argb_blend_pkg::B_MAX
                                                        : sum_b[4:0];
            res_n = (sum_n > 6'(argb_blend_pkg::NIB_MAX)) ? argb_blend_pkg::NIB_MAX
                                                          : sum_n[3:0];
            case (r_mul[i].mode)
                argb_blend_pkg::MODE_OPAQUE: begin
                    n_pix[i] = {r_mul[i].src_r, r_mul[i].src_g, r_mul[i].src_b};
                    n_nib[i] = argb_blend_pkg::NIB_MAX;
                end
                argb_blend_pkg::MODE_PASS: begin
                    n_pix[i] = r_mul[i].dst;
                    n_nib[i] = r_mul[i].nib;
                end
                default: begin
                    n_pix[i] = {res_r, res_g, res_b};
                    n_nib[i] = res_n;
                end
            endcase
        end
    end

    // Valid bits travel with the data; each stage holds while it cannot move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers, loaded only when a request moves in.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_dec <= n_dec;
        end
        if (w_rdy2 && r_v1) begin
            r_mul <= n_mul;
        end
        if (w_rdy3 && r_v2) begin
            r_pix <= n_pix;
            r_nib <= n_nib;
        end
    end

    assign o_out_valid      = r_v3;
    assign o_out_even       = r_pix[0];
    assign o_out_odd        = r_pix[1];
    assign o_out_alpha_pair = {r_nib[0], r_nib[1]};

endmodule
